### hw/rtl/mciir_pkg.sv
// Shared types, widths and codes for the multichannel direct form II IIR filter.
// Used by mciir_mul and by the top level multichannel_iir_direct_form_two.
`default_nettype none

package mciir_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int MAX_ORDER_DEF = 8;
  localparam int LANES         = 4;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 32;
  localparam int WORD_W   = 40;
  localparam int LO_W     = 24;
  localparam int HI_W     = WORD_W - LO_W;
  localparam int P_LO_W   = COEF_W + LO_W + 1;
  localparam int M_W      = COEF_W + HI_W + 1;
  localparam int FRAC_SH  = 4;
  localparam int TERM_W   = M_W - FRAC_SH;

  localparam logic [1:0] OP_PROCESS = 2'd0;
  localparam logic [1:0] OP_COEF    = 2'd1;
  localparam logic [1:0] OP_STEP    = 2'd2;
  localparam logic [1:0] OP_DELAY   = 2'd3;

  localparam logic REG_STEP_ENABLE = 1'b0;
  localparam logic REG_ORDER       = 1'b1;

  localparam logic [3:0] ORDER_RESET = 4'd2;

  typedef struct packed {
    logic signed [COEF_W-1:0] cb;
    logic signed [COEF_W-1:0] ca;
    logic signed [COEF_W-1:0] sb;
    logic signed [COEF_W-1:0] sa;
  } coef_row_t;

  typedef struct packed {
    logic lo_en;
    logic hi_en;
  } mul_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/multichannel_iir_direct_form_two.sv
// Process transfer: per channel a feedback pass over taps 1..n (n the clamped order in use) and
// a second pass over taps 0..MAX_ORDER, via the single memory read port and shared multiplier.
// Coefficient, step and delay-word write transfers pass a read state and a write-back state.
// One item is worked at a time; the next is taken while a result still waits at the output.
// Reset (synchronous, rst_n low) clears all coefficients, steps and delay words at once
// through per-entry valid bits, sets step_enable to 0 and order_in_use to 2.
`default_nettype none

module multichannel_iir_direct_form_two #(
  parameter int CHANNELS  = mciir_pkg::CHANNELS_DEF,
  parameter int MAX_ORDER = mciir_pkg::MAX_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic signed [23:0] in_sample_0,
  input  wire logic signed [23:0] in_sample_1,
  input  wire logic signed [23:0] in_sample_2,
  input  wire logic signed [23:0] in_sample_3,
  input  wire logic        in_coef_side,
  input  wire logic [3:0]  in_tap,
  input  wire logic [1:0]  in_channel,
  input  wire logic signed [31:0] in_value,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [23:0] out_0,
  output logic signed [23:0] out_1,
  output logic signed [23:0] out_2,
  output logic signed [23:0] out_3,
  output logic             out_saturated,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CB_DEPTH = CHANNELS * (MAX_ORDER + 1);
  localparam int DL_DEPTH = CHANNELS * MAX_ORDER;
  localparam int CB_AW    = (CB_DEPTH > 1) ? $clog2(CB_DEPTH) : 1;
  localparam int DL_AW    = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int K_W      = $clog2(MAX_ORDER + 1);
  localparam int ACC_W    = mciir_pkg::TERM_W + $clog2(MAX_ORDER + 2) + 1;
  localparam int SW       = mciir_pkg::SAMPLE_W;
  localparam int WW       = mciir_pkg::WORD_W;
  localparam int CW       = mciir_pkg::COEF_W;
  localparam int LN       = mciir_pkg::LANES;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WR_RD = 3'd1;
  localparam logic [2:0] S_WR_WB = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_LO    = 3'd4;
  localparam logic [2:0] S_HI    = 3'd5;
  localparam logic [2:0] S_ACC   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Control state.
  logic [2:0]      state_r;
  logic [CH_W-1:0] ch_r;
  logic [K_W-1:0]  k_r;
  logic [K_W-1:0]  n_r;
  logic            pass_r;      // 0 feedback pass, 1 feedforward/shift/ramp pass
  logic            sat_r;
  logic            out_valid_r;
  logic            step_en_r;
  logic [3:0]      order_r;
  logic            cv_r [CB_DEPTH];
  logic            dv_r [DL_DEPTH];

  // Item and datapath payload.
  logic [1:0]             op_r;
  logic                   side_r;
  logic signed [CW-1:0]   val_r;
  logic signed [SW-1:0]   samp_r [LN];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] y_r;
  logic signed [WW-1:0]   w0_r;
  logic signed [WW-1:0]   hold_r;
  logic signed [SW-1:0]   lane_r [LN];
  logic signed [SW-1:0]   out_y_r [LN];

  // Memories: one coefficient row per (channel, tap), one delay word per (channel, tap-1).
  mciir_pkg::coef_row_t cmem [CB_DEPTH];
  logic signed [WW-1:0] dmem [DL_DEPTH];
  mciir_pkg::coef_row_t cq_r;
  logic signed [WW-1:0] dq_r;
  logic                 cqv_r;
  logic                 dqv_r;

  logic [CB_AW-1:0]     caddr;
  logic [DL_AW-1:0]     daddr;
  logic                 mem_rd;
  logic                 cmem_we;
  logic                 dmem_we;
  mciir_pkg::coef_row_t cmem_wdata;
  logic signed [WW-1:0] dmem_wdata;
  mciir_pkg::coef_row_t cq;
  logic signed [WW-1:0] dq;

  mciir_pkg::mul_ctrl_t          mul_ctrl;
  logic signed [CW-1:0]          mul_coef;
  logic signed [WW-1:0]          mul_word;
  logic signed [mciir_pkg::TERM_W-1:0] term;

  logic                    in_xfer;
  logic                    cfg_wr;
  logic                    wr_ok;
  logic [K_W-1:0]          n_cl;
  logic signed [SW-1:0]    x_cur;
  logic signed [ACC_W-1:0] acc_sub;
  logic                    w0_ovf;
  logic signed [WW-1:0]    w0_sat;
  logic signed [ACC_W-1:0] y_add;
  logic signed [ACC_W-1:0] y_rnd;
  logic                    y_ovf;
  logic signed [SW-1:0]    y_sat;
  logic                    last_tap;
  logic                    last_ch;

  function automatic logic signed [31:0] ramp(input logic signed [31:0] c,
                                              input logic signed [31:0] s);
    logic signed [32:0] t;
    t = {c[31], c} + {s[31], s};
    if (t[32] != t[31]) begin
      ramp = t[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      ramp = t[31:0];
    end
  endfunction

  // Handshakes. The block takes a transfer only when the sequencer is free.
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == mciir_pkg::REG_ORDER) ? {28'd0, order_r}
                                                        : {31'd0, step_en_r};

  // A write is dropped when it names a channel or tap that does not exist,
  // or tap zero of the feedback side or of the delay line.
  assign wr_ok = (int'(in_channel) < CHANNELS) && (int'(in_tap) <= MAX_ORDER) &&
                 !((in_tap == 4'd0) && (in_operation == mciir_pkg::OP_DELAY || in_coef_side));

  // Order in use, clamped into 1..MAX_ORDER.
  always_comb begin
    if (order_r == 4'd0) begin
      n_cl = K_W'(1);
    end else if (int'(order_r) > MAX_ORDER) begin
      n_cl = K_W'(MAX_ORDER);
    end else begin
      n_cl = K_W'(order_r);
    end
  end

  // Sample of the current channel; channels past the reported lanes see zero input.
  always_comb begin
    x_cur = '0;
    for (int l = 0; l < LN; l++) begin
      if (int'(ch_r) == l) begin
        x_cur = samp_r[l];
      end
    end
  end

  // Addresses follow the channel and tap counters for both reads and write-back.
  assign caddr = CB_AW'(int'(ch_r) * (MAX_ORDER + 1) + int'(k_r));
  assign daddr = DL_AW'(int'(ch_r) * MAX_ORDER + ((k_r == '0) ? 0 : int'(k_r) - 1));

  assign mem_rd = (state_r == S_RD) || (state_r == S_WR_RD);
  assign cq     = cqv_r ? cq_r : '0;
  assign dq     = dqv_r ? dq_r : '0;

  // Multiplier operands: a[k]*w[k] in the feedback pass, b[k]*w[k] in the second,
  // where tap zero uses the freshly computed w0.
  assign mul_coef       = pass_r ? cq.cb : cq.ca;
  assign mul_word       = (pass_r && k_r == '0) ? w0_r : dq;
  assign mul_ctrl.lo_en = (state_r == S_LO);
  assign mul_ctrl.hi_en = (state_r == S_HI);

  mciir_mul u_mul (
    .clk  (clk),
    .ctrl (mul_ctrl),
    .coef (mul_coef),
    .word (mul_word),
    .term (term)
  );

  // w0 accumulation and its saturation to 40 bits.
  assign acc_sub = acc_r - ACC_W'(term);
  assign w0_ovf  = !((&acc_sub[ACC_W-1:WW-1]) || !(|acc_sub[ACC_W-1:WW-1]));
  assign w0_sat  = w0_ovf ? (acc_sub[ACC_W-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}})
                          : acc_sub[WW-1:0];

  // Output accumulation, rounding to an integer sample and saturation to 24 bits.
  assign y_add = y_r + ((k_r <= n_r) ? ACC_W'(term) : '0);
  assign y_rnd = (y_add + ACC_W'(128)) >>> 8;
  assign y_ovf = !((&y_rnd[ACC_W-1:SW-1]) || !(|y_rnd[ACC_W-1:SW-1]));
  assign y_sat = y_ovf ? (y_rnd[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}})
                       : y_rnd[SW-1:0];

  assign last_tap = (k_r == K_W'(MAX_ORDER));
  assign last_ch  = (ch_r == CH_W'(CHANNELS - 1));

  // Write-back: a coefficient-side write merges into the row just read; the second pass
  // ramps the row when step_enable is set and moves the previous delay word one tap down the line.
  always_comb begin
    cmem_we    = 1'b0;
    dmem_we    = 1'b0;
    cmem_wdata = cq;
    dmem_wdata = hold_r;
    if (state_r == S_WR_WB) begin
      case (op_r)
        mciir_pkg::OP_COEF: begin
          cmem_we = 1'b1;
          if (side_r) begin
            cmem_wdata.ca = val_r;
          end else begin
            cmem_wdata.cb = val_r;
          end
        end
        mciir_pkg::OP_STEP: begin
          cmem_we = 1'b1;
          if (side_r) begin
            cmem_wdata.sa = val_r;
          end else begin
            cmem_wdata.sb = val_r;
          end
        end
        mciir_pkg::OP_DELAY: begin
          dmem_we    = 1'b1;
          dmem_wdata = WW'(val_r);
        end
        default: begin
          cmem_we = 1'b0;
        end
      endcase
    end else if (state_r == S_ACC && pass_r) begin
      cmem_we       = step_en_r;
      cmem_wdata.cb = ramp(cq.cb, cq.sb);
      cmem_wdata.ca = ramp(cq.ca, cq.sa);
      dmem_we       = (k_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmem_we) begin
      cmem[caddr] <= cmem_wdata;
    end
    if (dmem_we) begin
      dmem[daddr] <= dmem_wdata;
    end
    if (mem_rd) begin
      cq_r  <= cmem[caddr];
      dq_r  <= dmem[daddr];
      cqv_r <= cv_r[caddr];
      dqv_r <= dv_r[daddr];
    end
  end

  // Control registers and sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_en_r   <= 1'b0;
      order_r     <= mciir_pkg::ORDER_RESET;
      ch_r        <= '0;
      k_r         <= '0;
      n_r         <= K_W'(1);
      pass_r      <= 1'b0;
      sat_r       <= 1'b0;
      for (int i = 0; i < CB_DEPTH; i++) begin
        cv_r[i] <= 1'b0;
      end
      for (int i = 0; i < DL_DEPTH; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == mciir_pkg::REG_ORDER) begin
          order_r <= pwdata[3:0];
        end else begin
          step_en_r <= pwdata[0];
        end
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cmem_we) begin
        cv_r[caddr] <= 1'b1;
      end
      if (dmem_we) begin
        dv_r[daddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_operation == mciir_pkg::OP_PROCESS) begin
              ch_r    <= '0;
              k_r     <= K_W'(1);
              pass_r  <= 1'b0;
              sat_r   <= 1'b0;
              n_r     <= n_cl;
              state_r <= S_RD;
            end else if (wr_ok) begin
              ch_r    <= CH_W'(in_channel);
              k_r     <= K_W'(in_tap);
              state_r <= S_WR_RD;
            end
          end
        end
        S_WR_RD: state_r <= S_WR_WB;
        S_WR_WB: state_r <= S_IDLE;
        S_RD:    state_r <= S_LO;
        S_LO:    state_r <= S_HI;
        S_HI:    state_r <= S_ACC;
        S_ACC: begin
          state_r <= S_RD;
          if (!pass_r) begin
            if (k_r == n_r) begin
              pass_r <= 1'b1;
              k_r    <= '0;
              if (w0_ovf) begin
                sat_r <= 1'b1;
              end
            end else begin
              k_r <= k_r + K_W'(1);
            end
          end else if (last_tap) begin
            if (y_ovf) begin
              sat_r <= 1'b1;
            end
            if (last_ch) begin
              state_r <= S_DONE;
            end else begin
              ch_r   <= ch_r + CH_W'(1);
              pass_r <= 1'b0;
              k_r    <= K_W'(1);
            end
          end else begin
            k_r <= k_r + K_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= in_operation;
      side_r    <= in_coef_side;
      val_r     <= in_value;
      samp_r[0] <= in_sample_0;
      samp_r[1] <= in_sample_1;
      samp_r[2] <= in_sample_2;
      samp_r[3] <= in_sample_3;
      if (in_operation == mciir_pkg::OP_PROCESS) begin
        for (int l = 0; l < LN; l++) begin
          lane_r[l] <= '0;
        end
      end
    end
    if (state_r == S_RD) begin
      if (!pass_r && k_r == K_W'(1)) begin
        acc_r <= ACC_W'($signed({x_cur, 8'h00}));
      end
      if (pass_r && k_r == '0) begin
        y_r <= '0;
      end
    end
    if (state_r == S_ACC) begin
      if (!pass_r) begin
        acc_r <= acc_sub;
        if (k_r == n_r) begin
          w0_r <= w0_sat;
        end
      end else begin
        y_r    <= y_add;
        hold_r <= (k_r == '0) ? w0_r : dq;
        if (last_tap) begin
          for (int l = 0; l < LN; l++) begin
            if (int'(ch_r) == l) begin
              lane_r[l] <= y_sat;
            end
          end
        end
      end
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      for (int l = 0; l < LN; l++) begin
        out_y_r[l] <= lane_r[l];
      end
      out_saturated <= sat_r;
    end
  end

  assign out_0 = out_y_r[0];
  assign out_1 = out_y_r[1];
  assign out_2 = out_y_r[2];
  assign out_3 = out_y_r[3];

  // The feedback pass only walks taps 1..n.
  a_fb_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && !pass_r) |-> (k_r != '0 && k_r <= n_r))
    else $error("feedback pass tap out of range");

  // The channel counter stays inside the configured channels while processing.
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_LO || state_r == S_HI || state_r == S_ACC)
      |-> (int'(ch_r) < CHANNELS))
    else $error("channel counter out of range");

  // A finished frame waits while the previous result has not been taken.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE && out_valid_r))
    else $error("result overwritten before transfer");

  // The single memory port never reads and writes in the same cycle.
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_rd && (cmem_we || dmem_we)))
    else $error("memory read and write collide");

endmodule

`default_nettype wire

### hw/rtl/mciir_mul.sv
// Two-step coefficient times delay-word multiplier: floor(coef * word / 2^28).
// Depends on mciir_pkg for widths and the control struct.
`default_nettype none

module mciir_mul (
  input  wire logic                                 clk,
  input  wire mciir_pkg::mul_ctrl_t                 ctrl,
  input  wire logic signed [mciir_pkg::COEF_W-1:0]  coef,
  input  wire logic signed [mciir_pkg::WORD_W-1:0]  word,
  output logic signed [mciir_pkg::TERM_W-1:0]       term
);

  logic signed [mciir_pkg::P_LO_W-1:0] p_lo_r;
  logic signed [mciir_pkg::M_W-1:0]    m_r;
  logic signed [mciir_pkg::LO_W:0]     w_lo;
  logic signed [mciir_pkg::HI_W-1:0]   w_hi;

  assign w_lo = $signed({1'b0, word[mciir_pkg::LO_W-1:0]});
  assign w_hi = word[mciir_pkg::WORD_W-1:mciir_pkg::LO_W];

  // The low partial product is taken first; the high one folds in its floored upper part.
  always_ff @(posedge clk) begin
    if (ctrl.lo_en) begin
      p_lo_r <= mciir_pkg::P_LO_W'(coef * w_lo);
    end
    if (ctrl.hi_en) begin
      m_r <= mciir_pkg::M_W'(coef * w_hi) + mciir_pkg::M_W'(p_lo_r >>> mciir_pkg::LO_W);
    end
  end

  assign term = mciir_pkg::TERM_W'(m_r >>> mciir_pkg::FRAC_SH);

endmodule

`default_nettype wire
